>>> hw/rtl/swmr_pkg.sv
// Shared constants and types for the sliding-window minimum row filter.
`timescale 1ns / 1ps

package swmr_pkg;

   // Widths of the item fields.
   localparam int SAMPLE_W    = 16;
   localparam int POSITION_W  = 12;
   localparam int WIDTH_REG_W = 6;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_MAX_WINDOW = 32;
   localparam int DEFAULT_MAX_ROW    = 4096;

   // Window width after reset.
   localparam logic [WIDTH_REG_W-1:0] RESET_WINDOW_WIDTH = WIDTH_REG_W'(2);

   // Register port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Operation broadcast to every cell of the candidate queue.
   typedef struct packed {
      logic                push;
      logic                retire;
      logic                clear;
      logic [SAMPLE_W-1:0] sample;
   } queue_op_type;

endpackage

>>> hw/rtl/swmr_queue_cell.sv
// One cell of the monotonic candidate queue.
`timescale 1ns / 1ps

module swmr_queue_cell
   import swmr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  queue_op_type        op,
   input  logic                prev_kept,
   input  logic [SAMPLE_W-1:0] next_value,
   input  logic                next_occupied,
   output logic [SAMPLE_W-1:0] value,
   output logic                occupied,
   output logic                kept
);

   logic [SAMPLE_W-1:0] value_ff;
   logic [SAMPLE_W-1:0] value_in;
   logic                occupied_ff;
   logic                occupied_in;

   // A candidate survives a push unless the new sample is strictly smaller.
   assign kept = occupied_ff && !(op.sample < value_ff);

   // Next contents: the first cell that is not kept takes the new sample,
   // the cells behind it empty; a retire shifts the row one place forward.
   always_comb begin
      value_in    = value_ff;
      occupied_in = occupied_ff;
      if (op.clear) begin
         occupied_in = 1'b0;
      end else if (op.push) begin
         if (!kept) begin
            if (prev_kept) begin
               value_in    = op.sample;
               occupied_in = 1'b1;
            end else begin
               occupied_in = 1'b0;
            end
         end
      end else if (op.retire) begin
         value_in    = next_value;
         occupied_in = next_occupied;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign occupied = occupied_ff;

endmodule

>>> hw/rtl/swmr_queue_row.sv
// Row of queue cells holding the candidate minima, oldest at the front.
`timescale 1ns / 1ps

module swmr_queue_row
   import swmr_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_WINDOW
)
(
   input  logic                clock,
   input  logic                reset,
   input  queue_op_type        op,
   output logic [SAMPLE_W-1:0] front_value,
   output logic                front_occupied
);

   logic [SAMPLE_W-1:0] cell_value [DEPTH];
   logic                cell_occupied [DEPTH];
   logic                cell_kept [DEPTH];

   // Each cell looks at its left neighbour for the push and at its right
   // neighbour for the retire shift.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                prev_kept;
      logic [SAMPLE_W-1:0] next_value;
      logic                next_occupied;

      if (i == 0) begin : g_first
         assign prev_kept = 1'b1;
      end else begin : g_inner
         assign prev_kept = cell_kept[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_value    = '0;
         assign next_occupied = 1'b0;
      end else begin : g_body
         assign next_value    = cell_value[i+1];
         assign next_occupied = cell_occupied[i+1];
      end

      swmr_queue_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .op            (op),
         .prev_kept     (prev_kept),
         .next_value    (next_value),
         .next_occupied (next_occupied),
         .value         (cell_value[i]),
         .occupied      (cell_occupied[i]),
         .kept          (cell_kept[i])
      );
   end

   // An empty queue reads as zero.
   assign front_occupied = cell_occupied[0];
   assign front_value    = cell_occupied[0] ? cell_value[0] : '0;

endmodule

>>> hw/rtl/swmr_line_buffer.sv
// Shift line of the most recent samples, newest at tap 0, with one read tap.
`timescale 1ns / 1ps

module swmr_line_buffer
   import swmr_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_WINDOW
)
(
   input  logic                     clock,
   input  logic                     shift_en,
   input  logic [SAMPLE_W-1:0]      din,
   input  logic [$clog2(DEPTH)-1:0] tap_sel,
   output logic [SAMPLE_W-1:0]      tap_data
);

   logic [SAMPLE_W-1:0] taps_ff [DEPTH];

   // Every accepted sample moves the line one place along.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         taps_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
      end
   end

   assign tap_data = taps_ff[tap_sel];

endmodule

>>> hw/rtl/sliding_window_min_row_filter.sv
// Top level of the sliding-window minimum row filter.
//
// Samples of one row enter on the req_ channel, one per item, with
// req_row_end set on the last sample of the row. Result x of a row is the
// minimum of samples x to x+w-1 and leaves on the rsp_ channel with its
// column; near the row end the windows shrink and the row-end sample
// flushes all pending results, the last one flagged rsp_last_of_row.
// The window width w is set through the csr_ register port, by the user
// only while idle; the block does not enforce this. An item that completes
// k windows holds req_stall while its k results issue, one result per
// cycle while the output register is free, set by the single retire per
// cycle in the candidate queue cells and the one output register. While
// rsp_stall is high the output register holds and the result loop waits;
// a new item may be taken while a result still waits. Reset empties the
// queue, zeroes the row counters and sets w to 2; the sample line is not
// cleared and no clearing pass is needed.
`timescale 1ns / 1ps

module sliding_window_min_row_filter
   import swmr_pkg::*;
#(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
   parameter int MAX_ROW    = DEFAULT_MAX_ROW
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic                  req_row_end,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SAMPLE_W-1:0]   rsp_window_min,
   output logic [POSITION_W-1:0] rsp_position,
   output logic                  rsp_last_of_row,
   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LAG_W = $clog2(MAX_WINDOW + 1);
   localparam int TAP_W = $clog2(MAX_WINDOW);
   localparam int ROW_W = $clog2(MAX_ROW);

   localparam logic REG_WINDOW_WIDTH = 1'b0;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   logic [LAG_W-1:0]      pending_ff;
   logic [LAG_W-1:0]      pending_in;
   logic [ROW_W-1:0]      out_idx_ff;
   logic [ROW_W-1:0]      out_idx_in;
   logic                  row_end_ff;
   logic                  row_end_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_min_ff;
   logic [SAMPLE_W-1:0]   rsp_min_in;
   logic [POSITION_W-1:0] rsp_pos_ff;
   logic [POSITION_W-1:0] rsp_pos_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;
   logic [WIDTH_REG_W-1:0] width_ff;

   logic                  accept;
   logic                  fire;
   logic                  csr_write;
   logic [WIDTH_REG_W:0]  width_ext;
   logic [LAG_W-1:0]      eff_width;
   logic [LAG_W-1:0]      lag_after_push;
   logic [LAG_W-1:0]      lag_after_emit;
   logic                  last_result;
   logic [SAMPLE_W-1:0]   front_value;
   logic                  front_occupied;
   logic [SAMPLE_W-1:0]   leaving_sample;
   logic [ROW_W+POSITION_W-1:0] idx_wide;
   queue_op_type          queue_op;

   // Register port: a single window width register, always ready.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_WIDTH) ?
                       CSR_DATA_W'(width_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_WINDOW_WIDTH;
      end else if (csr_write && csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_WIDTH) begin
         width_ff <= csr_pwdata[WIDTH_REG_W-1:0];
      end
   end

   // Effective width: zero acts as one, anything above the limit is clamped.
   assign width_ext = {1'b0, width_ff};
   always_comb begin
      if (width_ff == '0) begin
         eff_width = LAG_W'(1);
      end else if (width_ext > (WIDTH_REG_W + 1)'(MAX_WINDOW)) begin
         eff_width = LAG_W'(MAX_WINDOW);
      end else begin
         eff_width = LAG_W'(width_ext);
      end
   end

   // Handshake of both channels.
   assign req_stall = (state_ff == ST_EMIT);
   assign accept    = req_valid && !req_stall;
   assign fire      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign lag_after_push = pending_ff + LAG_W'(1);
   assign lag_after_emit = pending_ff - LAG_W'(1);
   assign last_result    = row_end_ff && (pending_ff == LAG_W'(1));

   // Queue operation: push on an accepted item, retire the front when the
   // sample leaving the window matches it, clear after the row flush.
   always_comb begin
      queue_op.push   = accept;
      queue_op.retire = fire && front_occupied && (front_value == leaving_sample);
      queue_op.clear  = fire && last_result;
      queue_op.sample = req_sample;
   end

   swmr_queue_row #(
      .DEPTH (MAX_WINDOW)
   ) u_queue (
      .clock          (clock),
      .reset          (reset),
      .op             (queue_op),
      .front_value    (front_value),
      .front_occupied (front_occupied)
   );

   swmr_line_buffer #(
      .DEPTH (MAX_WINDOW)
   ) u_line (
      .clock    (clock),
      .shift_en (accept),
      .din      (req_sample),
      .tap_sel  (TAP_W'(lag_after_emit)),
      .tap_data (leaving_sample)
   );

   assign idx_wide = (ROW_W + POSITION_W)'(out_idx_ff);

   // Sequencer: take an item, then, while the output register is free, issue
   // one result per cycle while a window is complete or the row is flushed.
   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      out_idx_in   = out_idx_ff;
      row_end_in   = row_end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_min_in   = rsp_min_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pending_in = lag_after_push;
               row_end_in = req_row_end;
               if (req_row_end || lag_after_push >= eff_width) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = front_value;
               rsp_pos_in   = idx_wide[POSITION_W-1:0];
               rsp_last_in  = last_result;
               pending_in   = lag_after_emit;
               if (out_idx_ff == ROW_W'(MAX_ROW - 1)) begin
                  out_idx_in = '0;
               end else begin
                  out_idx_in = out_idx_ff + ROW_W'(1);
               end
               if (lag_after_emit == '0 ||
                   (!row_end_ff && lag_after_emit < eff_width)) begin
                  state_in = ST_IDLE;
               end
               if (last_result) begin
                  pending_in = '0;
                  out_idx_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         out_idx_ff   <= '0;
         row_end_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         out_idx_ff   <= out_idx_in;
         row_end_ff   <= row_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_min_ff  <= rsp_min_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_min  = rsp_min_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_last_of_row = rsp_last_ff;

`ifndef SYNTHESIS
   // The pending count never exceeds the line length.
   a_pending_bound : assert property (@(posedge clock) disable iff (reset)
      pending_ff <= LAG_W'(MAX_WINDOW))
      else $error("pending count beyond window limit");

   // A result is only issued from a non-empty window.
   a_fire_pending : assert property (@(posedge clock) disable iff (reset)
      fire |-> pending_ff != '0)
      else $error("result issued with nothing pending");

   // The candidate queue holds the window minimum whenever a result leaves.
   a_fire_queue : assert property (@(posedge clock) disable iff (reset)
      fire |-> front_occupied)
      else $error("result issued from an empty queue");

   // After the final result of a row the block is idle with counters cleared.
   a_row_flush : assert property (@(posedge clock) disable iff (reset)
      fire && last_result |=> state_ff == ST_IDLE && pending_ff == '0 &&
                              out_idx_ff == '0 && !front_occupied)
      else $error("row flush left state behind");
`endif

endmodule

>>> tb/tb_sliding_window_min_row_filter.sv
// Self-checking testbench for the sliding-window minimum row filter.
`timescale 1ns / 1ps

module tb_sliding_window_min_row_filter
   import swmr_pkg::*;
();

   localparam int MAX_WIN          = DEFAULT_MAX_WINDOW;
   localparam int REG_WINDOW_WIDTH = 0;
   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR = CSR_ADDR_W'(4 * REG_WINDOW_WIDTH);
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_ITEMS     = 400;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   window_min;
      logic [POSITION_W-1:0] position;
      logic                  last_of_row;
   } window_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  req_row_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_window_min;
   logic [POSITION_W-1:0] rsp_position;
   logic                  rsp_last_of_row;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Idling switches for the sending and the receiving side.
   bit src_idle_on  = 1'b0;
   bit sink_idle_on = 1'b0;

   int mismatch_count = 0;

   // Predictor state: candidate minima, recent samples, row counters, width.
   logic [SAMPLE_W-1:0]    cand_min[$];
   logic [SAMPLE_W-1:0]    line_buf[MAX_WIN];
   logic [POSITION_W-1:0]  taken_cnt  = '0;
   logic [POSITION_W-1:0]  issued_cnt = '0;
   logic [WIDTH_REG_W-1:0] width_reg  = RESET_WINDOW_WIDTH;
   window_result_type      pending_windows[$];
   window_result_type      due_r;

   sliding_window_min_row_filter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_row_end     (req_row_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_min  (rsp_window_min),
      .rsp_position    (rsp_position),
      .rsp_last_of_row (rsp_last_of_row),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // The run is cut off here if the block hangs.
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("mismatch on %s: got %0d, wanted %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic int effective_width();
      int w;
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > MAX_WIN) w = MAX_WIN;
      return w;
   endfunction

   // Works out the windows that one accepted sample completes.
   function automatic void predict_windows(input logic [SAMPLE_W-1:0] s, input logic row_end);
      int                    w;
      int                    lag;
      int                    n;
      logic [POSITION_W-1:0] diff;
      window_result_type     r;
      w = effective_width();
      while (cand_min.size() > 0 && s < cand_min[$]) cand_min.delete(cand_min.size() - 1);
      if (cand_min.size() < MAX_WIN) cand_min = {cand_min, s};
      for (int i = MAX_WIN - 1; i > 0; i--) line_buf[i] = line_buf[i-1];
      line_buf[0] = s;
      taken_cnt++;
      diff = taken_cnt - issued_cnt;
      lag = int'(diff);
      if (lag > MAX_WIN) lag = MAX_WIN;
      n = 0;
      while (lag > 0 && (row_end || lag >= w) && n < MAX_WIN) begin
         r.window_min  = (cand_min.size() > 0) ? cand_min[0] : '0;
         r.position    = issued_cnt;
         r.last_of_row = row_end && (lag == 1);
         pending_windows = {pending_windows, r};
         // The sample leaving the window drops out if it heads the candidates.
         if (cand_min.size() > 0 && cand_min[0] == line_buf[lag-1]) cand_min.delete(0);
         issued_cnt++;
         lag--;
         n++;
      end
      if (row_end) begin
         cand_min.delete();
         taken_cnt  = '0;
         issued_cnt = '0;
      end
   endfunction

   // Sends one item, with an optional gap in front; returns at a falling edge.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic row_end);
      if (src_idle_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= s;
      req_row_end <= row_end;
      do @(posedge clock); while (req_stall);
      predict_windows(s, row_end);
      @(negedge clock);
   endtask

   // Holds the sender back until every expected result has come out.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_windows.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the window width while the block is idle and reads it back.
   task automatic write_width(input logic [WIDTH_REG_W-1:0] v);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom();
      word[WIDTH_REG_W-1:0] = v;
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WIDTH_ADDR;
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      width_reg = v;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(v))
         report_mismatch("window_width readback", longint'(csr_prdata), longint'(v));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // The receiving side stalls in random bursts while its idling is on.
   initial begin
      forever begin
         @(negedge clock);
         if (sink_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each result item is compared with the oldest expected window.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_windows.size() == 0) begin
            report_mismatch("result with none expected, position",
                            longint'(rsp_position), -1);
         end else begin
            due_r = pending_windows[0];
            pending_windows.delete(0);
            if (rsp_window_min !== due_r.window_min)
               report_mismatch("window_min", longint'(rsp_window_min),
                               longint'(due_r.window_min));
            if (rsp_position !== due_r.position)
               report_mismatch("position", longint'(rsp_position),
                               longint'(due_r.position));
            if (rsp_last_of_row !== due_r.last_of_row)
               report_mismatch("last_of_row", longint'(rsp_last_of_row),
                               longint'(due_r.last_of_row));
         end
      end
   end

   // Reset width of two, with the extremes of the sample field.
   task automatic test_default_width();
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);
   endtask

   // A width of one passes samples straight through; zero behaves as one.
   task automatic test_unit_and_zero_width();
      write_width(6'd1);
      send_sample(16'd5, 1'b0);
      send_sample(16'd3, 1'b0);
      send_sample(16'd9, 1'b1);
      write_width(6'd0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b1);
   endtask

   // Rows shorter than the window, down to a single sample.
   task automatic test_short_rows();
      write_width(6'd8);
      send_sample(16'd7, 1'b0);
      send_sample(16'd2, 1'b0);
      send_sample(16'd5, 1'b1);
      send_sample(16'hABCD, 1'b1);
   endtask

   // Narrowing the window part-way along a row releases several results at once.
   task automatic test_width_change_mid_row();
      write_width(6'd10);
      for (int k = 0; k < 7; k++) send_sample(16'(9 - k), 1'b0);
      write_width(6'd3);
      send_sample(16'd4, 1'b0);
      send_sample(16'd1, 1'b0);
      send_sample(16'd8, 1'b1);
   endtask

   // Rows of random length and content, with width changes between and within rows.
   task automatic test_random_rows();
      int                     sent;
      int                     len;
      int                     mode;
      int                     w_eff;
      logic [SAMPLE_W-1:0]    base;
      logic [SAMPLE_W-1:0]    s;
      logic [WIDTH_REG_W-1:0] w;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // The last part of the run goes without idling.
         if (sent >= RANDOM_ITEMS * 4 / 5) begin
            src_idle_on  = 1'b0;
            sink_idle_on = 1'b0;
         end else begin
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
         end
         if (sent == 0) begin
            write_width(6'd63);
         end else if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0:       w = 6'd0;
               1:       w = 6'd32;
               2:       w = 6'($urandom_range(33, 63));
               3:       w = 6'd1;
               default: w = 6'($urandom_range(2, 12));
            endcase
            write_width(w);
         end
         w_eff = effective_width();
         case ($urandom_range(0, 7))
            0:       len = $urandom_range(1, 3);
            1:       len = w_eff + $urandom_range(20, 40);
            default: len = $urandom_range(w_eff, w_eff + 16);
         endcase
         if (sent == 0) len = 40;
         mode = $urandom_range(0, 4);
         base = 16'($urandom());
         for (int k = 0; k < len; k++) begin
            if (k > 0 && k < len - 1 && $urandom_range(0, 39) == 0)
               write_width(6'($urandom_range(1, 16)));
            case (mode)
               0:       s = 16'($urandom_range(0, 65535));
               1:       s = 16'($urandom_range(0, 3));
               2:       s = base - 16'(k * 37);
               3:       s = base + 16'(k * 53);
               default: s = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            endcase
            send_sample(s, k == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      test_default_width();
      test_unit_and_zero_width();
      test_short_rows();
      test_width_change_mid_row();
      test_random_rows();
      wait_idle();
      repeat (24) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/swmr_pkg.sv
hw/rtl/swmr_queue_cell.sv
hw/rtl/swmr_queue_row.sv
hw/rtl/swmr_line_buffer.sv
hw/rtl/sliding_window_min_row_filter.sv
tb/tb_sliding_window_min_row_filter.sv
